>>> hdl/isp_pkg.sv
// shared types, constants and tables for the interrupted sinusoidal projection
package isp_pkg;

  localparam int ANGLE_FRAC_BITS = 28;
  localparam int WORK_FRAC_BITS  = 30;
  localparam int QSH             = WORK_FRAC_BITS - ANGLE_FRAC_BITS;

  localparam int QUEUE_DEPTH  = 4;
  localparam int HORNER_STEPS = 8;
  localparam int DIV_STEPS    = 31;

  // operation codes
  localparam logic OP_FWD = 1'b0;
  localparam logic OP_INV = 1'b1;

  typedef logic signed [35:0] isp_q30_t;

  localparam isp_q30_t ONE_Q   = 36'sd1073741824;
  localparam isp_q30_t PI2_Q   = 36'sd1686629713;
  localparam isp_q30_t PI_Q    = 36'sd3373259426;
  localparam isp_q30_t TWOPI_Q = 36'sd6746518852;
  localparam isp_q30_t SAT_MAX = 36'sd2147483647;
  localparam isp_q30_t SAT_MIN = -36'sd2147483648;

  localparam logic [63:0] PI2_Q61  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q61   = 64'h6487ED5110B4611A;
  localparam logic [63:0] THR_HALF = PI2_Q61 >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] THR_PI   = PI_Q61 >> (61 - ANGLE_FRAC_BITS);

  // horner divisors (2k)(2k-1) for k = 8 down to 1, and floor(2^36 / m)
  localparam logic [7:0] HORNER_M [HORNER_STEPS] = '{
    8'd240, 8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [35:0] HORNER_RECIP [HORNER_STEPS] = '{
    36'((64'd1 << 36) / 64'd240), 36'((64'd1 << 36) / 64'd182),
    36'((64'd1 << 36) / 64'd132), 36'((64'd1 << 36) / 64'd90),
    36'((64'd1 << 36) / 64'd56),  36'((64'd1 << 36) / 64'd30),
    36'((64'd1 << 36) / 64'd12),  36'((64'd1 << 36) / 64'd2)
  };

  typedef struct packed {
    logic              op;
    logic signed [31:0] a;
    logic              fwd_rej;
    logic              b_neg;
    logic              neg;
    isp_q30_t          r1;
    isp_q30_t          dp;
    isp_q30_t          dm;
  } isp_ctx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } isp_qstat_t;

  typedef struct packed {
    logic                 op;
    logic signed [31:0]   a;
    logic                 ok;
    logic                 negq;
    logic                 west;
    isp_q30_t             fx30;
    logic [31:0]          c;
    logic [31:0]          rem;
    logic [DIV_STEPS-1:0] num;
    logic [DIV_STEPS-1:0] quo;
  } isp_div_t;

endpackage

>>> hdl/isp_ifs.sv
// handshake channel interfaces for input points and projected results
interface isp_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] coord_first;
  logic signed [31:0] coord_second;
  modport source (output valid, operation, coord_first, coord_second, input ready);
  modport sink (input valid, operation, coord_first, coord_second, output ready);
endinterface

interface isp_out_if;
  logic               valid;
  logic               ready;
  logic               result_valid;
  logic signed [31:0] result_first;
  logic signed [31:0] result_second;
  modport source (output valid, result_valid, result_first, result_second, input ready);
  modport sink (input valid, result_valid, result_first, result_second, output ready);
endinterface

>>> hdl/isp_front.sv
// front end: takes transactions, checks the forward domain, prepares angles for the queue
module isp_front (
  isp_in_if.sink                  in_ch,
  input  isp_pkg::isp_qstat_t     qstat,
  output logic                    push,
  output isp_pkg::isp_ctx_t       entry
);

  logic [32:0]       abs_a;
  logic [32:0]       abs_b;
  isp_pkg::isp_q30_t aq;
  isp_pkg::isp_q30_t dq;

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && !qstat.full;

  always_comb begin
    abs_a = in_ch.coord_first[31] ? 33'(-$signed({in_ch.coord_first[31], in_ch.coord_first}))
                                  : 33'(in_ch.coord_first);
    abs_b = in_ch.coord_second[31] ? 33'(-$signed({in_ch.coord_second[31], in_ch.coord_second}))
                                   : 33'(in_ch.coord_second);
    aq = 36'(in_ch.coord_first) <<< isp_pkg::QSH;
    dq = 36'(in_ch.coord_second) <<< isp_pkg::QSH;

    entry.op      = in_ch.operation;
    entry.a       = in_ch.coord_first;
    entry.fwd_rej = (abs_a > isp_pkg::THR_HALF[32:0]) || (abs_b > isp_pkg::THR_PI[32:0]);
    entry.b_neg   = in_ch.coord_second[31];
    entry.neg     = 1'b0;
    // truncating remainder by 2*pi; one subtraction suffices for this input range
    if (aq >= isp_pkg::TWOPI_Q) begin
      entry.r1 = aq - isp_pkg::TWOPI_Q;
    end else if (aq <= -isp_pkg::TWOPI_Q) begin
      entry.r1 = aq + isp_pkg::TWOPI_Q;
    end else begin
      entry.r1 = aq;
    end
    entry.dp = dq + isp_pkg::PI2_Q;
    entry.dm = dq - isp_pkg::PI2_Q;
  end

endmodule

>>> hdl/isp_queue.sv
// small fifo between the front end and the compute pipeline
module isp_queue #(
  parameter int DEPTH = isp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  isp_pkg::isp_ctx_t   wr_data,
  input  logic                pop,
  output isp_pkg::isp_ctx_t   rd_data,
  output isp_pkg::isp_qstat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  isp_pkg::isp_ctx_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/isp_cos_step.sv
// one horner step of the cosine series, t = 1 - x2*t/(m*2^30), three register stages
module isp_cos_step (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        x2_i,
  input  logic signed [33:0] t_i,
  input  logic [7:0]         div_m,
  input  logic [35:0]        div_recip,
  output logic [31:0]        x2_o,
  output logic signed [33:0] t_o
);

  logic signed [66:0] p_r;
  logic [31:0]        x2a_r, x2b_r, x2c_r;
  logic [66:0]        pabs;
  logic [32:0]        q;
  logic [32:0]        q_r;
  logic               neg_r;
  logic [68:0]        est_r;
  logic [32:0]        est;
  logic [40:0]        rem;
  logic [32:0]        quot;
  logic signed [33:0] t_r;

  always_comb begin
    pabs = p_r[66] ? 67'(-p_r) : 67'(p_r);
    q    = pabs[62:30];
    est  = est_r[68:36];
    // reciprocal estimate is at most one short
    rem  = {8'b0, q_r} - est * div_m;
    quot = est + 33'(rem >= {33'b0, div_m});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= $signed({1'b0, x2_i}) * t_i;
      x2a_r <= x2_i;
      est_r <= q * div_recip;
      q_r   <= q;
      neg_r <= p_r[66];
      x2b_r <= x2a_r;
      t_r   <= neg_r ? 34'(isp_pkg::ONE_Q) + $signed({1'b0, quot})
                     : 34'(isp_pkg::ONE_Q) - $signed({1'b0, quot});
      x2c_r <= x2b_r;
    end
  end

  assign x2_o = x2c_r;
  assign t_o  = t_r;

endmodule

>>> hdl/isp_back.sv
// back end: cosine pipeline, lobe selection, pipelined divider and output register
module isp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  isp_pkg::isp_ctx_t   head,
  input  isp_pkg::isp_qstat_t qstat,
  output logic                pop,
  isp_out_if.source           out_ch
);

  localparam int NCOS   = isp_pkg::HORNER_STEPS;
  localparam int NDIV   = isp_pkg::DIV_STEPS;
  localparam int S_C    = 4 + 3 * NCOS;
  localparam int S_P1   = S_C + 2;
  localparam int NCTX   = S_C + 2;
  localparam int NSTG   = S_P1 + NDIV + 2;

  logic              en;
  logic [NSTG-1:0]   vld_r;
  isp_pkg::isp_ctx_t ctx_r [NCTX];
  isp_pkg::isp_ctx_t s1_ctx;

  isp_pkg::isp_q30_t  rf;
  logic [31:0]        rabs_r;
  logic [30:0]        x_r;
  logic [61:0]        xx_r;
  logic [62:0]        xx_rnd;
  logic [31:0]        x2_r;
  logic [31:0]        hx2 [NCOS+1];
  logic signed [33:0] ht  [NCOS+1];

  logic signed [33:0] c_r, c1_r;
  logic signed [34:0] fd;
  logic signed [66:0] prodf_r;
  logic signed [63:0] rhs_r;
  logic [35:0]        mw_r, me_r;
  logic signed [66:0] pr;
  logic               west, east;
  logic [31:0]        mag;
  isp_pkg::isp_div_t  d0;
  isp_pkg::isp_div_t  dv_r [NDIV+1];

  isp_pkg::isp_q30_t  qs;
  isp_pkg::isp_q30_t  res30_r;
  logic               ok_l_r, op_l_r;
  logic signed [31:0] a_l_r;
  isp_pkg::isp_q30_t  rr;
  logic signed [31:0] rsat;

  logic               out_vld_r;
  logic               res_vld_r;
  logic signed [31:0] res_first_r, res_second_r;

  function automatic isp_pkg::isp_div_t div_step(input isp_pkg::isp_div_t d);
    logic [32:0]       r2;
    isp_pkg::isp_div_t o;
    o     = d;
    r2    = {d.rem, d.num[NDIV-1]};
    o.num = {d.num[NDIV-2:0], 1'b0};
    if (r2 >= {1'b0, d.c}) begin
      o.rem = 32'(r2 - {1'b0, d.c});
      o.quo = {d.quo[NDIV-2:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.quo = {d.quo[NDIV-2:0], 1'b0};
    end
    return o;
  endfunction

  assign en  = !out_vld_r || out_ch.ready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NSTG-2:0], pop};
      out_vld_r <= vld_r[NSTG-1];
    end
  end

  // fold the reduced angle into [0, pi]
  always_comb begin
    if (head.r1 > isp_pkg::PI_Q) begin
      rf = head.r1 - isp_pkg::TWOPI_Q;
    end else if (head.r1 < -isp_pkg::PI_Q) begin
      rf = head.r1 + isp_pkg::TWOPI_Q;
    end else begin
      rf = head.r1;
    end
    s1_ctx     = ctx_r[0];
    s1_ctx.neg = rabs_r > isp_pkg::PI2_Q[31:0];
    xx_rnd     = {1'b0, xx_r} + (63'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= head;
      ctx_r[1] <= s1_ctx;
      for (int i = 2; i < NCTX; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
      rabs_r <= rf[35] ? 32'(-rf) : rf[31:0];
      // cos(a) = -cos(pi - a) above pi/2
      x_r    <= s1_ctx.neg ? 31'(isp_pkg::PI_Q[31:0] - rabs_r) : rabs_r[30:0];
      xx_r   <= x_r * x_r;
      x2_r   <= xx_rnd[61:30];
    end
  end

  assign hx2[0] = x2_r;
  assign ht[0]  = 34'(isp_pkg::ONE_Q);

  for (genvar g = 0; g < NCOS; g++) begin : g_cos
    isp_cos_step u_step (
      .clk       (clk),
      .en        (en),
      .x2_i      (hx2[g]),
      .t_i       (ht[g]),
      .div_m     (isp_pkg::HORNER_M[g]),
      .div_recip (isp_pkg::HORNER_RECIP[g]),
      .x2_o      (hx2[g+1]),
      .t_o       (ht[g+1])
    );
  end

  always_comb begin
    fd   = ctx_r[S_C].b_neg ? ctx_r[S_C].dp[34:0] : ctx_r[S_C].dm[34:0];
    pr   = prodf_r + (67'sd1 <<< 29);
    west = (mw_r[35:32] == '0) &&
           ($signed({2'b00, mw_r[31:0], 30'd0}) < rhs_r);
    east = (me_r[35:32] == '0) &&
           ($signed({2'b00, me_r[31:0], 30'd0}) <= rhs_r);
    mag  = west ? mw_r[31:0] : me_r[31:0];

    d0.op   = ctx_r[S_C+1].op;
    d0.a    = ctx_r[S_C+1].a;
    d0.ok   = (ctx_r[S_C+1].op == isp_pkg::OP_INV) ? ((c1_r > 34'sd0) && (west || east))
                                                   : !ctx_r[S_C+1].fwd_rej;
    d0.negq = west ? ctx_r[S_C+1].dp[35] : ctx_r[S_C+1].dm[35];
    d0.west = west;
    d0.fx30 = pr[65:30] + (ctx_r[S_C+1].b_neg ? -isp_pkg::PI2_Q : isp_pkg::PI2_Q);
    d0.c    = c1_r[31:0];
    // quotient fits 31 bits when a lobe matches, so start with the top bits brought down
    d0.rem  = {1'b0, mag[31:1]};
    d0.num  = {mag[0], (NDIV-1)'(0)};
    d0.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r     <= ctx_r[S_C-1].neg ? -ht[NCOS] : ht[NCOS];
      prodf_r <= fd * $signed(c_r[31:0]);
      rhs_r   <= $signed({1'b0, isp_pkg::PI2_Q[30:0]}) * $signed(c_r[31:0]);
      mw_r    <= ctx_r[S_C].dp[35] ? 36'(-ctx_r[S_C].dp) : ctx_r[S_C].dp;
      me_r    <= ctx_r[S_C].dm[35] ? 36'(-ctx_r[S_C].dm) : ctx_r[S_C].dm;
      c1_r    <= c_r;
      dv_r[0] <= d0;
      for (int j = 0; j < NDIV; j++) begin
        dv_r[j+1] <= div_step(dv_r[j]);
      end
    end
  end

  always_comb begin
    qs = $signed({(36 - NDIV)'(0), dv_r[NDIV].quo});
    if (dv_r[NDIV].negq) begin
      qs = -qs;
    end
    rr = (res30_r + (36'sd1 <<< (isp_pkg::QSH - 1))) >>> isp_pkg::QSH;
    if (rr > isp_pkg::SAT_MAX) begin
      rsat = isp_pkg::SAT_MAX[31:0];
    end else if (rr < isp_pkg::SAT_MIN) begin
      rsat = isp_pkg::SAT_MIN[31:0];
    end else begin
      rsat = rr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res30_r <= (dv_r[NDIV].op == isp_pkg::OP_INV)
                 ? qs + (dv_r[NDIV].west ? -isp_pkg::PI2_Q : isp_pkg::PI2_Q)
                 : dv_r[NDIV].fx30;
      ok_l_r  <= dv_r[NDIV].ok;
      op_l_r  <= dv_r[NDIV].op;
      a_l_r   <= dv_r[NDIV].a;
      res_vld_r <= ok_l_r;
      if (!ok_l_r) begin
        res_first_r  <= '0;
        res_second_r <= '0;
      end else if (op_l_r == isp_pkg::OP_INV) begin
        res_first_r  <= a_l_r;
        res_second_r <= rsat;
      end else begin
        res_first_r  <= rsat;
        res_second_r <= a_l_r;
      end
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.result_valid  = res_vld_r;
  assign out_ch.result_first  = res_first_r;
  assign out_ch.result_second = res_second_r;

endmodule

>>> hdl/interrupted_sinusoidal_projection.sv
// top level of the two-lobe interrupted sinusoidal projection. Takes one point per cycle
// while the queue is not full, forward (latitude/longitude to x/y) or inverse (x/y to
// latitude/longitude), in signed Q3.28 radians, and gives one result per point in the order
// taken; a point outside the domain comes back with result_valid low and zero coordinates.
// Throughput is one point a cycle when nothing stalls. A point is written into the input
// queue, read straight into four stages that reduce and square the angle, then the eight
// three-stage steps of the cosine series, three stages for the sign, lobe products and
// divider set-up, the 31 one-bit stages of the inverse divider and two to round and
// register the result. The four-entry queue lets the input keep taking points while the
// result side stalls, until it is full.
module interrupted_sinusoidal_projection #(
  parameter int QUEUE_DEPTH = isp_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  isp_in_if.sink    in_ch,
  isp_out_if.source out_ch
);

  logic                q_push;
  logic                q_pop;
  isp_pkg::isp_ctx_t   q_wr;
  isp_pkg::isp_ctx_t   q_rd;
  isp_pkg::isp_qstat_t q_stat;

  isp_front u_front (
    .in_ch (in_ch),
    .qstat (q_stat),
    .push  (q_push),
    .entry (q_wr)
  );

  isp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  isp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_rd),
    .qstat  (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !q_pop)
    else $error("pipeline advanced while output stalled");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !q_pop) |=> !q_stat.empty)
    else $error("queue lost entries");

endmodule
